// ===== rtl/msl_pkg.sv =====
// Shared constants, types and codes for the multi-stack leftmost-fill block.
package msl_pkg;

  localparam int NUM_STACKS = 16;
  localparam int MAX_DEPTH  = 16;

  localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int DEPTH_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_STACKS * MAX_DEPTH);

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int CAP_W   = 5;
  localparam int ACT_W   = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_POP_AT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/multi_stack_leftmost_fill.sv =====
// Multi-stack leftmost-fill block: push to leftmost non-full stack, pop from right or named stack.
// In the idle state a transaction is accepted: the per-stack counts pick the stack and slot,
// the plate memory is written on a successful push and the addressed word is read into a
// register; in the response state the registered word and flags move into the output register
// once it is free, and only then is a new transaction accepted. Counts sit in flip-flops cleared
// by reset; plates sit in a NUM_STACKS*MAX_DEPTH x 32 synchronous memory.
module multi_stack_leftmost_fill
  import msl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] push_value, [35:32] stack_index, rest 0
  input  logic [ACT_W-1:0]       in_tuser,   // [1:0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] popped_value
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] nothing_popped, [1] push_rejected
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]   capacity_r;
  logic [CNT_W-1:0]   count_r [NUM_STACKS];
  logic [VALUE_W-1:0] plate_mem [NUM_STACKS * MAX_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  logic res_pop_r, res_push_r, res_hit_r;
  logic out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  action_t            act;
  logic [VALUE_W-1:0] push_value;
  logic [INDEX_W-1:0] at_index;
  logic               accept, load;
  logic [CNT_W-1:0]   cap_eff;
  logic [NUM_STACKS-1:0] full, nonempty;
  logic               push_found, pop_found, at_in_range;
  logic [STACK_W-1:0] push_stack, pop_stack, at_stack, sel_stack;
  logic               hit;
  logic [CNT_W-1:0]   cnt_sel, cnt_dec;
  logic [DEPTH_W-1:0] slot;
  logic [ADDR_W-1:0]  addr;

  assign act        = action_t'(in_tuser);
  assign push_value = in_tdata[VALUE_W-1:0];
  assign at_index   = in_tdata[VALUE_W+INDEX_W-1:VALUE_W];
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity_r) > MAX_DEPTH) begin
      cap_eff = CNT_W'(MAX_DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_STACKS; s++) begin
      full[s]     = (count_r[s] >= cap_eff);
      nonempty[s] = (count_r[s] != '0);
    end
  end

  // Leftmost stack with room.
  always_comb begin
    push_found = 1'b0;
    push_stack = '0;
    for (int s = NUM_STACKS - 1; s >= 0; s--) begin
      if (!full[s]) begin
        push_found = 1'b1;
        push_stack = STACK_W'(s);
      end
    end
  end

  // Rightmost stack holding a plate.
  always_comb begin
    pop_found = 1'b0;
    pop_stack = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (nonempty[s]) begin
        pop_found = 1'b1;
        pop_stack = STACK_W'(s);
      end
    end
  end

  assign at_in_range = (int'(at_index) < NUM_STACKS);
  assign at_stack    = STACK_W'(at_index);

  always_comb begin
    sel_stack = '0;
    hit       = 1'b0;
    unique case (act)
      ACT_PUSH: begin
        sel_stack = push_stack;
        hit       = push_found;
      end
      ACT_POP: begin
        sel_stack = pop_stack;
        hit       = pop_found;
      end
      ACT_POP_AT: begin
        sel_stack = at_stack;
        hit       = at_in_range && nonempty[at_stack];
      end
      default: begin
        sel_stack = '0;
        hit       = 1'b0;
      end
    endcase
  end

  assign cnt_sel = count_r[sel_stack];
  assign cnt_dec = cnt_sel - CNT_W'(1);
  assign slot    = (act == ACT_PUSH) ? cnt_sel[DEPTH_W-1:0] : cnt_dec[DEPTH_W-1:0];
  assign addr    = ADDR_W'(sel_stack) * ADDR_W'(MAX_DEPTH) + ADDR_W'(slot);

  // Plate memory: a write on each successful push, and a read on every accepted transaction.
  always_ff @(posedge clk) begin
    if (accept && act == ACT_PUSH && hit) begin
      plate_mem[addr] <= push_value;
    end
    if (accept) begin
      rd_data_r <= plate_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        count_r[s] <= '0;
      end
    end else if (accept && hit) begin
      if (act == ACT_PUSH) begin
        count_r[sel_stack] <= cnt_sel + CNT_W'(1);
      end else begin
        count_r[sel_stack] <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_pop_r  <= (act == ACT_POP) || (act == ACT_POP_AT);
      res_push_r <= (act == ACT_PUSH);
      res_hit_r  <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_tready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r    <= (res_pop_r && res_hit_r) ? rd_data_r : '0;
      out_user_r[0] <= res_pop_r && !res_hit_r;
      out_user_r[1] <= res_push_r && !res_hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/msl_checker.sv =====
// Port-level checker for the multi-stack leftmost-fill block, with its bind.
module msl_checker
  import msl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [ACT_W-1:0]       in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   cfg_wr_en,
  input logic [CAP_W-1:0]       cfg_wr_data
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("nothing_popped and push_rejected both set");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |-> out_tdata == '0)
    else $error("flagged result carries a nonzero value");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction accepted on back-to-back cycles");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind multi_stack_leftmost_fill msl_checker u_msl_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the multi-stack leftmost-fill block.
module testbench;
  import msl_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RAND_PHASES    = 9;
  localparam int RAND_PER_PHASE = 175;

  typedef struct {
    action_t              act;
    logic [VALUE_W-1:0]   value;
    logic [INDEX_W-1:0]   idx;
  } plate_op_t;

  typedef struct {
    logic [VALUE_W-1:0]   popped_value;
    logic                 nothing_popped;
    logic                 push_rejected;
  } plate_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  // Shadow copy of the stacks and the capacity register
  logic [VALUE_W-1:0]     plate_mem [NUM_STACKS][MAX_DEPTH];
  int                     plate_cnt [NUM_STACKS];
  logic [CAP_W-1:0]       cap_shadow = CAP_RESET;

  plate_op_t              op_queue[$];
  plate_result_t          predicted_results[$];
  plate_op_t              next_op;
  plate_result_t          want;
  plate_result_t          got;
  logic                   in_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_issued = 0;
  int n_accepted = 0;
  int n_pushes = 0;
  int n_refused = 0;
  int n_pops = 0;
  int n_empty_pops = 0;
  int n_cap_writes = 0;
  int err_cnt = 0;

  multi_stack_leftmost_fill u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] push_value, [35:32] stack_index, rest 0
    .in_tuser   (in_tuser),   // [1:0] action
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] popped_value
    .out_tuser  (out_tuser),  // [0] nothing_popped, [1] push_rejected
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (plate_cnt[s]) plate_cnt[s] = 0;
  end

  function automatic plate_result_t predict_plate_op(action_t act, logic [VALUE_W-1:0] val,
                                                     logic [INDEX_W-1:0] idx);
    plate_result_t r;
    int lim;
    int s;
    bit found;
    r.popped_value   = '0;
    r.nothing_popped = 1'b0;
    r.push_rejected  = 1'b0;
    found = 0;
    case (act)
      ACT_PUSH: begin
        lim = (cap_shadow == 0) ? 1 : ((cap_shadow > MAX_DEPTH) ? MAX_DEPTH : int'(cap_shadow));
        r.push_rejected = 1'b1;
        // leftmost stack that is not full; overfilled stacks count as full
        for (s = 0; s < NUM_STACKS; s++) begin
          if (plate_cnt[s] < lim) begin
            plate_mem[s][plate_cnt[s]] = val;
            plate_cnt[s]++;
            r.push_rejected = 1'b0;
            break;
          end
        end
      end
      ACT_POP: begin
        for (s = NUM_STACKS - 1; s >= 0 && !found; s--) begin
          if (plate_cnt[s] > 0) begin
            plate_cnt[s]--;
            r.popped_value = plate_mem[s][plate_cnt[s]];
            found = 1;
          end
        end
        r.nothing_popped = !found;
      end
      ACT_POP_AT: begin
        if (idx < NUM_STACKS && plate_cnt[idx] > 0) begin
          plate_cnt[idx]--;
          r.popped_value = plate_mem[idx][plate_cnt[idx]];
        end else begin
          r.nothing_popped = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Driver: present the next transaction at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = op_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_TDATA_W - VALUE_W - INDEX_W){1'b0}}, next_op.idx, next_op.value};
          in_tuser  <= next_op.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check results first, then predict newly accepted transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (cfg_wr_en) cap_shadow = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.popped_value   = out_tdata;
        got.nothing_popped = out_tuser[0];
        got.push_rejected  = out_tuser[1];
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending: tdata=%h tuser=%b",
                                    out_tdata, out_tuser));
        end else begin
          want = predicted_results.pop_front();
          if (got.popped_value !== want.popped_value)
            report_mismatch($sformatf("popped_value %h, want %h",
                                      got.popped_value, want.popped_value));
          if (got.nothing_popped !== want.nothing_popped)
            report_mismatch($sformatf("nothing_popped %b, want %b",
                                      got.nothing_popped, want.nothing_popped));
          if (got.push_rejected !== want.push_rejected)
            report_mismatch($sformatf("push_rejected %b, want %b",
                                      got.push_rejected, want.push_rejected));
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_plate_op(action_t'(in_tuser), in_tdata[VALUE_W-1:0],
                                in_tdata[VALUE_W +: INDEX_W]);
        predicted_results.insert(predicted_results.size(), want);
        n_accepted++;
        if (action_t'(in_tuser) == ACT_PUSH) begin
          n_pushes++;
          if (want.push_rejected) n_refused++;
        end else if (action_t'(in_tuser) != ACT_NONE) begin
          n_pops++;
          if (want.nothing_popped) n_empty_pops++;
        end
      end
    end
  end

  task automatic queue_op(action_t act, logic [VALUE_W-1:0] val, logic [INDEX_W-1:0] idx);
    plate_op_t op;
    op.act   = act;
    op.value = val;
    op.idx   = idx;
    op_queue.insert(op_queue.size(), op);
    n_issued++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] corner [5];
    corner = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    if ($urandom_range(9) == 0) return corner[$urandom_range(4)];
    return $urandom;
  endfunction

  // Bursts are fill-heavy or drain-heavy, picked at random, so the stacks reach full and empty
  task automatic queue_random(int count);
    int left;
    int push_pct;
    int r;
    action_t act;
    left = 0;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(60, 10);
        push_pct = $urandom_range(1) ? 85 : 20;
      end
      left--;
      r = $urandom_range(99);
      if (r < 3)
        act = ACT_NONE;
      else if (r < push_pct)
        act = ACT_PUSH;
      else if ($urandom_range(1))
        act = ACT_POP;
      else
        act = ACT_POP_AT;
      queue_op(act, pick_value(),
               INDEX_W'($urandom_range(1) ? $urandom_range(15) : $urandom_range(3)));
    end
  endtask

  // Hold off new input until every result has come back
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_issued || predicted_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    n_cap_writes++;
  endtask

  initial begin
    logic [CAP_W-1:0] caps [RAND_PHASES];
    caps = '{5'd31, 5'd16, 5'd3, 5'd1, 5'd8, 5'd2, 5'd0, 5'd12, 5'd16};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 13;
    recv_idle_pct = 76;

    // Empty pops, unused action, value extremes, LIFO order within one stack
    queue_op(ACT_POP, 32'h0, 4'h0);
    queue_op(ACT_POP_AT, 32'hFFFF_FFFF, 4'hF);
    queue_op(ACT_NONE, 32'hFFFF_FFFF, 4'hF);
    queue_op(ACT_PUSH, 32'h7FFF_FFFF, 4'h0);
    queue_op(ACT_PUSH, 32'h8000_0000, 4'hF);
    queue_op(ACT_PUSH, 32'hFFFF_FFFF, 4'h5);
    queue_op(ACT_POP_AT, 32'h0, 4'h0);
    queue_op(ACT_POP, 32'h0, 4'h0);
    queue_op(ACT_POP, 32'h0, 4'h0);
    wait_drained();

    // Capacity zero behaves as one: fill every stack, then one push must be refused
    write_capacity(5'd0);
    for (int i = 0; i <= NUM_STACKS; i++)
      queue_op(ACT_PUSH, $urandom, INDEX_W'($urandom_range(15)));
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 76;
      end else if (p < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Stacks keep their plates across phases, so lowering the capacity overfills some
      write_capacity(caps[p]);
      queue_random(RAND_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d transactions across %0d capacity settings (0, 1 and 31 among them).",
             n_accepted, n_cap_writes);
    $display("Pushes %0d (%0d refused on full), pops %0d (%0d found nothing).",
             n_pushes, n_refused, n_pops, n_empty_pops);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Timed out with %0d results outstanding.", predicted_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
